[rtl/core/dust_triggered_cleaning_controller_macros.svh]
// Assertion macros for the dust-triggered cleaning controller.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef DUST_TRIGGERED_CLEANING_CONTROLLER_MACROS_SVH
`define DUST_TRIGGERED_CLEANING_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DTCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtcc: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define DTCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtcc: next-cycle check failed");

`endif

[rtl/core/dtcc_pkg.sv]
// Shared types and constants of the dust-triggered cleaning controller.
// No dependencies; used by dtcc_step and the top level.
package dtcc_pkg;

  localparam int unsigned DustLimitW  = 9;
  localparam int unsigned WaterLimitW = 6;
  localparam int unsigned SpeedW      = 7;

  localparam logic [DustLimitW-1:0]  DustLimitRst  = 9'd100;
  localparam logic [WaterLimitW-1:0] WaterLimitRst = 6'd20;
  localparam logic [SpeedW-1:0]      SpeedRst      = 7'd60;
  localparam logic [SpeedW-1:0]      SpeedMax      = 7'd100;
  localparam logic [SpeedW-1:0]      SpeedStep     = 7'd10;

  // Register indexes on the configuration port
  localparam logic RegDustLimit  = 1'b0;
  localparam logic RegWaterLimit = 1'b1;

  // Event codes
  typedef enum logic [2:0] {
    CMD_EVALUATE = 3'd0,
    CMD_BT_BYTE  = 3'd1,
    CMD_FAN_TGL  = 3'd2,
    CMD_MIST_TGL = 3'd3,
    CMD_BRUSH_TGL = 3'd4,
    CMD_SET_SPEED = 3'd5,
    CMD_SYNC     = 3'd6,
    CMD_APPLY    = 3'd7
  } cmd_e;

  // Bluetooth command bytes (ASCII)
  localparam logic [7:0] BtBrushOn  = 8'h31;  // '1'
  localparam logic [7:0] BtBrushOff = 8'h30;  // '0'
  localparam logic [7:0] BtSpeedUp  = 8'h2B;  // '+'
  localparam logic [7:0] BtSpeedDn  = 8'h2D;  // '-'
  localparam logic [7:0] BtFanUc    = 8'h46;  // 'F'
  localparam logic [7:0] BtFanLc    = 8'h66;  // 'f'
  localparam logic [7:0] BtMistUc   = 8'h57;  // 'W'
  localparam logic [7:0] BtMistLc   = 8'h77;  // 'w'

  // Controller state
  typedef struct packed {
    logic              fan;
    logic              mist;
    logic              brush;
    logic              auto_on;
    logic              fan_veto;
    logic              mist_veto;
    logic              brush_veto;
    logic [SpeedW-1:0] speed;
    logic              dirty;
  } state_t;

  localparam state_t StateRst = '{
    fan: 1'b0, mist: 1'b0, brush: 1'b0, auto_on: 1'b0,
    fan_veto: 1'b0, mist_veto: 1'b0, brush_veto: 1'b0,
    speed: SpeedRst, dirty: 1'b1
  };

endpackage

[rtl/core/dtcc_step.sv]
// Next-state logic for one event of the cleaning controller.
// Purely combinational; depends on dtcc_pkg.
module dtcc_step (
  input  dtcc_pkg::state_t                    state_i,
  input  logic [2:0]                          cmd_i,
  input  logic [15:0]                         dust_level_i,
  input  logic [6:0]                          water_level_i,
  input  logic [7:0]                          bt_byte_i,
  input  logic [6:0]                          speed_value_i,
  input  logic [dtcc_pkg::DustLimitW-1:0]     dust_limit_i,
  input  logic [dtcc_pkg::WaterLimitW-1:0]    water_limit_i,
  output dtcc_pkg::state_t                    state_o,
  output logic                                strobe_o
);
  import dtcc_pkg::*;

  state_t           n;
  logic             fv, mv, bv;
  logic             dust_hi, water_ok;
  logic [SpeedW:0]  speed_up;

  assign dust_hi  = dust_level_i >= {7'd0, dust_limit_i};
  assign water_ok = water_level_i >= {1'b0, water_limit_i};
  assign speed_up = {1'b0, state_i.speed} + {1'b0, SpeedStep};

  // Vetoes seen by evaluate: cleared when auto cleaning is just starting
  assign fv = state_i.auto_on & state_i.fan_veto;
  assign mv = state_i.auto_on & state_i.mist_veto;
  assign bv = state_i.auto_on & state_i.brush_veto;

  always_comb begin
    n        = state_i;
    strobe_o = 1'b0;
    case (cmd_e'(cmd_i))
      CMD_EVALUATE: begin
        if (dust_hi) begin
          n.auto_on    = 1'b1;
          n.fan_veto   = fv;
          n.mist_veto  = mv;
          n.brush_veto = bv;
          if (!fv) n.fan = 1'b1;
          if (!bv) n.brush = 1'b1;
          if (water_ok) begin
            if (!mv) n.mist = 1'b1;
          end else begin
            n.mist = 1'b0;
          end
        end else if (state_i.auto_on) begin
          n.auto_on = 1'b0;
          if (!state_i.fan_veto)   n.fan = 1'b0;
          if (!state_i.mist_veto)  n.mist = 1'b0;
          if (!state_i.brush_veto) n.brush = 1'b0;
          n.fan_veto   = 1'b0;
          n.mist_veto  = 1'b0;
          n.brush_veto = 1'b0;
        end
        if ((n.fan != state_i.fan) || (n.mist != state_i.mist) ||
            (n.brush != state_i.brush)) begin
          n.dirty = 1'b1;
        end
      end
      CMD_BT_BYTE: begin
        case (bt_byte_i)
          BtBrushOn: begin
            n.brush = 1'b1;
            n.dirty = 1'b1;
          end
          BtBrushOff: begin
            n.brush = 1'b0;
            n.dirty = 1'b1;
          end
          BtSpeedUp: begin
            n.speed = (speed_up > {1'b0, SpeedMax}) ? SpeedMax : speed_up[SpeedW-1:0];
            if (state_i.brush) n.dirty = 1'b1;
          end
          BtSpeedDn: begin
            n.speed = (state_i.speed < SpeedStep) ? '0 : state_i.speed - SpeedStep;
            if (state_i.brush) n.dirty = 1'b1;
          end
          BtFanUc, BtFanLc: begin
            n.fan   = ~state_i.fan;
            n.dirty = 1'b1;
          end
          BtMistUc, BtMistLc: begin
            n.mist  = ~state_i.mist;
            n.dirty = 1'b1;
          end
          default: ;
        endcase
      end
      // Menu toggles: veto the actuator if turned off during auto cleaning
      CMD_FAN_TGL: begin
        n.fan      = ~state_i.fan;
        n.dirty    = 1'b1;
        n.fan_veto = state_i.fan & state_i.auto_on;
      end
      CMD_MIST_TGL: begin
        n.mist      = ~state_i.mist;
        n.dirty     = 1'b1;
        n.mist_veto = state_i.mist & state_i.auto_on;
      end
      CMD_BRUSH_TGL: begin
        n.brush      = ~state_i.brush;
        n.dirty      = 1'b1;
        n.brush_veto = state_i.brush & state_i.auto_on;
      end
      CMD_SET_SPEED: begin
        n.speed = (speed_value_i > SpeedMax) ? SpeedMax : speed_value_i;
        if (state_i.brush) n.dirty = 1'b1;
      end
      CMD_SYNC: n.dirty = 1'b1;
      CMD_APPLY: begin
        if (state_i.dirty) begin
          n.dirty  = 1'b0;
          strobe_o = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign state_o = n;

endmodule

[rtl/core/dust_triggered_cleaning_controller.sv]
// Top level of the dust-triggered cleaning controller: handshakes,
// configuration registers and state. Depends on dtcc_pkg and dtcc_step.
//
// One request is taken every clock cycle while in_stall_o is low, and each
// gives one result. A request is held in an input register, dtcc_step
// computes the new state from it combinationally, and the result register
// shows the drives after the event. Stalling the output holds the result
// and, once the input register is also full, stalls the input. Limits are
// written through the APB port at byte addresses 0 (dust_limit) and 4
// (water_limit); both can be read back.
`include "dust_triggered_cleaning_controller_macros.svh"

module dust_triggered_cleaning_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] dust_level_i,
  input  logic [6:0]  water_level_i,
  input  logic [7:0]  bt_byte_i,
  input  logic [6:0]  speed_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        fan_drive_o,
  output logic        mist_drive_o,
  output logic        brush_drive_o,
  output logic [6:0]  brush_duty_o,
  output logic        auto_active_o,
  output logic        apply_strobe_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dtcc_pkg::*;

  logic [DustLimitW-1:0]  dust_limit_q;
  logic [WaterLimitW-1:0] water_limit_q;
  logic                   cfg_wr;

  logic        in_valid_q;
  logic [2:0]  cmd_q;
  logic [15:0] dust_q;
  logic [6:0]  water_q;
  logic [7:0]  bt_q;
  logic [6:0]  spd_q;

  state_t state_q, state_d;
  logic   strobe_d;
  logic   out_valid_q, out_hold, adv;
  logic   fan_q, mist_q, brush_q, auto_q, strobe_q;
  logic [SpeedW-1:0] duty_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == RegWaterLimit) ? {26'd0, water_limit_q}
                                              : {23'd0, dust_limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dust_limit_q  <= DustLimitRst;
      water_limit_q <= WaterLimitRst;
    end else if (cfg_wr) begin
      if (paddr[2] == RegDustLimit) dust_limit_q <= pwdata[DustLimitW-1:0];
      else                          water_limit_q <= pwdata[WaterLimitW-1:0];
    end
  end

  // Flow control
  assign out_hold   = out_valid_q & out_stall_i;
  assign adv        = in_valid_q & ~out_hold;
  assign in_stall_o = in_valid_q & out_hold;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q   <= cmd_i;
      dust_q  <= dust_level_i;
      water_q <= water_level_i;
      bt_q    <= bt_byte_i;
      spd_q   <= speed_value_i;
    end
  end

  // Event logic
  dtcc_step u_step (
    .state_i       (state_q),
    .cmd_i         (cmd_q),
    .dust_level_i  (dust_q),
    .water_level_i (water_q),
    .bt_byte_i     (bt_q),
    .speed_value_i (spd_q),
    .dust_limit_i  (dust_limit_q),
    .water_limit_i (water_limit_q),
    .state_o       (state_d),
    .strobe_o      (strobe_d)
  );

  // State, updated as each request moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= adv | out_hold;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fan_q    <= state_d.fan;
      mist_q   <= state_d.mist;
      brush_q  <= state_d.brush;
      duty_q   <= state_d.speed;
      auto_q   <= state_d.auto_on;
      strobe_q <= strobe_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fan_drive_o    = fan_q;
  assign mist_drive_o   = mist_q;
  assign brush_drive_o  = brush_q;
  assign brush_duty_o   = duty_q;
  assign auto_active_o  = auto_q;
  assign apply_strobe_o = strobe_q;

  // Assertions
  `DTCC_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_q)
  `DTCC_ASSERT_NOW(a_hold_blocks_adv, out_hold, !adv)
  `DTCC_ASSERT_NOW(a_veto_needs_auto, !state_q.auto_on,
                   !state_q.fan_veto && !state_q.mist_veto && !state_q.brush_veto)
  `DTCC_ASSERT_NOW(a_speed_in_range, 1'b1, state_q.speed <= SpeedMax)

endmodule
